>>> hw/rtl/dspp_pkg.sv
// Shared types, widths and codes of the damper stepper position planner.
`default_nettype none

package dspp_pkg;

    // Field widths.
    localparam int POS_W      = 15;
    localparam int PCT_W      = 8;
    localparam int DIR_W      = 2;
    localparam int OP_W       = 2;
    localparam int OPCT_W     = 7;
    localparam int WD_W       = 16;
    localparam int PROD_W     = POS_W + PCT_W;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 72;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Operation codes carried on s_tuser.
    localparam logic [OP_W-1:0] OP_PLAN  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPLY = 2'd1;
    localparam logic [OP_W-1:0] OP_SET   = 2'd2;

    // Two-bit signed direction codes.
    localparam logic [DIR_W-1:0] DIR_NONE  = 2'b00;
    localparam logic [DIR_W-1:0] DIR_OPEN  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_CLOSE = 2'b11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TGT_MUL,
        ST_TGT_DIV,
        ST_PLAN_FIN,
        ST_PCT,
        ST_PCT_MUL,
        ST_PCT_DIV,
        ST_EMIT
    } dspp_state_t;

    typedef struct packed {
        logic               start;
        logic [POS_W-1:0]   mcand;
        logic [PCT_W-1:0]   mplier;
    } dspp_mul_req_t;

    typedef struct packed {
        logic               start;
        logic [PROD_W-1:0]  num;
        logic [POS_W-1:0]   den;
    } dspp_div_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/dspp_ser_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none

module dspp_ser_mul (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire dspp_pkg::dspp_mul_req_t     req,
    output logic                             done,
    output logic [dspp_pkg::PROD_W-1:0]      product
);
    import dspp_pkg::*;

    localparam int CNT_W = $clog2(PCT_W);

    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [POS_W-1:0]  mcand_reg;
    logic [PCT_W-1:0]  mplier_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              last;

    assign last = (cnt_reg == CNT_W'(PCT_W - 1));

    // MSB first: double the partial sum and add the multiplicand when the bit is set.
    always_comb begin
        acc_next = {acc_reg[PROD_W-2:0], 1'b0} +
                   (mplier_reg[PCT_W-1] ? PROD_W'(mcand_reg) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && last;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg    <= '0;
            mcand_reg  <= req.mcand;
            mplier_reg <= req.mplier;
            cnt_reg    <= '0;
        end else if (busy_reg) begin
            acc_reg    <= acc_next;
            mplier_reg <= {mplier_reg[PCT_W-2:0], 1'b0};
            cnt_reg    <= cnt_reg + 1'b1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dspp_ser_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module dspp_ser_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire dspp_pkg::dspp_div_req_t     req,
    output logic                             done,
    output logic [dspp_pkg::PROD_W-1:0]      quotient
);
    import dspp_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic [PROD_W-1:0] num_reg;
    logic [POS_W-1:0]  rem_reg;
    logic [POS_W-1:0]  den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              last;
    logic [POS_W:0]    trial;
    logic [POS_W:0]    diff;
    logic              fits;

    assign last = (cnt_reg == CNT_W'(PROD_W - 1));

    // Bring down the next numerator bit and subtract the divisor if it fits.
    always_comb begin
        trial = {rem_reg, num_reg[PROD_W-1]};
        fits  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && last;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[PROD_W-2:0], fits};
            rem_reg <= fits ? diff[POS_W-1:0] : trial[POS_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire

>>> hw/rtl/damper_stepper_position_planner.sv
// Top level of the damper stepper position planner: control sequencer and state.
`default_nettype none

// The planner keeps the damper position in steps and a flag that says
// whether that position is known, and takes one request at a time on the
// s_ stream; the operation code travels on s_tuser. A plan request turns a
// target open percent into an absolute step target, a direction, a step
// count and a stall watchdog of five quarters of the steps, rounded up; it
// fails with all plan fields at zero when the position is unknown or the
// travel range is zero. An apply request moves the position by the steps
// taken and clamps it to the travel range. A set request loads a homed
// position and marks it known. Every request yields exactly one result on
// the m_ stream, which always carries the current position and its rounded
// open percent. Products and quotients go through a bit-serial multiplier
// and a bit-serial restoring divider. The open percent is loaded directly
// when it is fixed (position unknown, zero or at full travel, or no range)
// and is otherwise divided out with the multiplier and the divider; a
// successful plan first runs the target multiply and divide. The next
// request is accepted in the cycle after the result is loaded. The result
// sits in an output register, so the next request is taken while the
// previous result still waits for m_tready.
// The travel range is written on the cfg_ port, which is always ready, and
// should only be changed while no request is in flight.
module damper_stepper_position_planner #(
    parameter int PERCENT_FULL = 100
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration: travel range in steps.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dspp_pkg::POS_W-1:0]       cfg_data,
    // Request stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata, low bit up: target_pct[7:0], move_direction[9:8],
    // step_amount[24:10], zero fill[31:25].
    input  wire logic [dspp_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: operation[1:0].
    input  wire logic [dspp_pkg::OP_W-1:0]        s_tuser,
    // Result stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata, low bit up: plan_ok[0], plan_direction[2:1], plan_steps[17:3],
    // plan_target[32:18], watchdog_limit[48:33], current_position[63:49],
    // current_open_pct[70:64], position_known[71].
    output logic [dspp_pkg::M_TDATA_W-1:0]        m_tdata
);
    import dspp_pkg::*;

    localparam logic [PCT_W-1:0]  PF_PCT  = PCT_W'(PERCENT_FULL);
    localparam logic [OPCT_W-1:0] PF_OPCT = OPCT_W'(PERCENT_FULL);
    localparam logic [PROD_W-1:0] PF_HALF = PROD_W'(PERCENT_FULL / 2);

    typedef struct packed {
        logic s_ready;
        logic exec_plan;
        logic exec_other;
        logic tgt_load;
        logic plan_load;
        logic pct_fixed;
        logic pct_load;
        logic out_load;
    } ctl_t;

    dspp_state_t state_reg, state_next;
    ctl_t        ctl;

    // Architectural state.
    logic [POS_W-1:0]  range_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              known_reg;

    // Captured request.
    logic [OP_W-1:0]   op_reg;
    logic [PCT_W-1:0]  tpct_reg;
    logic [DIR_W-1:0]  mdir_reg;
    logic [POS_W-1:0]  amt_reg;

    // Result fields under construction.
    logic              ok_reg;
    logic [DIR_W-1:0]  pdir_reg, pdir_next;
    logic [POS_W-1:0]  steps_reg, steps_next;
    logic [POS_W-1:0]  target_reg;
    logic [WD_W-1:0]   wd_reg;
    logic [OPCT_W-1:0] opct_reg, opct_fixed;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic              plan_go;
    logic              pct_is_fixed;
    logic [PCT_W-1:0]  tpct_clamped;
    logic [POS_W:0]    move_sum;
    logic [POS_W:0]    move_pos;
    logic [WD_W-1:0]   steps_round;

    dspp_mul_req_t     mul_req;
    dspp_div_req_t     div_req;
    logic              mul_done, div_done;
    logic [PROD_W-1:0] mul_prod, div_quot;

    dspp_ser_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    dspp_ser_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    // A plan only proceeds with a known position and a calibrated range.
    assign plan_go      = (op_reg == OP_PLAN) && known_reg && (range_reg != '0);
    assign tpct_clamped = (tpct_reg > PF_PCT) ? PF_PCT : tpct_reg;

    // The open percent needs no division when the position is unknown,
    // there is no range, the damper is closed or it is at full travel.
    always_comb begin
        pct_is_fixed = 1'b1;
        opct_fixed   = '0;
        if (!known_reg || (range_reg == '0) || (pos_reg == '0)) begin
            opct_fixed = '0;
        end else if (pos_reg >= range_reg) begin
            opct_fixed = PF_OPCT;
        end else begin
            pct_is_fixed = 1'b0;
        end
    end

    // Apply: move by the reported steps, then clamp to the range and to
    // the width of the position.
    always_comb begin
        move_sum = {1'b0, pos_reg} + {1'b0, amt_reg};
        if (mdir_reg == DIR_OPEN) begin
            move_pos = move_sum;
        end else if (mdir_reg[DIR_W-1]) begin
            move_pos = (amt_reg >= pos_reg) ? '0 : {1'b0, pos_reg - amt_reg};
        end else begin
            move_pos = {1'b0, pos_reg};
        end
        if ((range_reg != '0) && (move_pos > {1'b0, range_reg})) begin
            move_pos = {1'b0, range_reg};
        end
        if (move_pos > {1'b0, POS_MAX}) begin
            move_pos = {1'b0, POS_MAX};
        end
    end

    always_comb begin
        unique case (op_reg)
            OP_APPLY: pos_next = move_pos[POS_W-1:0];
            OP_SET:   pos_next = amt_reg;
            default:  pos_next = pos_reg;
        endcase
    end

    // Plan direction and step count from the divided-out target.
    always_comb begin
        if (target_reg > pos_reg) begin
            pdir_next  = DIR_OPEN;
            steps_next = target_reg - pos_reg;
        end else if (target_reg < pos_reg) begin
            pdir_next  = DIR_CLOSE;
            steps_next = pos_reg - target_reg;
        end else begin
            pdir_next  = DIR_NONE;
            steps_next = '0;
        end
    end

    // Watchdog: steps + ceil(steps / 4).
    assign steps_round = (WD_W'(steps_reg) + WD_W'(3)) >> 2;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC:     state_next = plan_go ? ST_TGT_MUL : ST_PCT;
            ST_TGT_MUL:  if (mul_done) state_next = ST_TGT_DIV;
            ST_TGT_DIV:  if (div_done) state_next = ST_PLAN_FIN;
            ST_PLAN_FIN: state_next = ST_PCT;
            ST_PCT:      state_next = pct_is_fixed ? ST_EMIT : ST_PCT_MUL;
            ST_PCT_MUL:  if (mul_done) state_next = ST_PCT_DIV;
            ST_PCT_DIV:  if (div_done) state_next = ST_EMIT;
            ST_EMIT:     if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs and arithmetic unit requests.
    always_comb begin
        ctl            = '0;
        mul_req        = '0;
        div_req        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ctl.s_ready = 1'b1;
            end
            ST_EXEC: begin
                if (plan_go) begin
                    ctl.exec_plan  = 1'b1;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = range_reg;
                    mul_req.mplier = tpct_clamped;
                end else begin
                    ctl.exec_other = 1'b1;
                end
            end
            ST_TGT_MUL: begin
                if (mul_done) begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_prod + PF_HALF;
                    div_req.den   = POS_W'(PF_PCT);
                end
            end
            ST_TGT_DIV: begin
                ctl.tgt_load = div_done;
            end
            ST_PLAN_FIN: begin
                ctl.plan_load = 1'b1;
            end
            ST_PCT: begin
                if (pct_is_fixed) begin
                    ctl.pct_fixed = 1'b1;
                end else begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = pos_reg;
                    mul_req.mplier = PF_PCT;
                end
            end
            ST_PCT_MUL: begin
                if (mul_done) begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_prod + PROD_W'(range_reg >> 1);
                    div_req.den   = range_reg;
                end
            end
            ST_PCT_DIV: begin
                ctl.pct_load = div_done;
            end
            ST_EMIT: begin
                ctl.out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    // Control state and architectural registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            range_reg    <= '0;
            pos_reg      <= '0;
            known_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                range_reg <= cfg_data;
            end
            if (ctl.exec_other) begin
                pos_reg <= pos_next;
                if (op_reg == OP_SET) begin
                    known_reg <= 1'b1;
                end
            end
            if (ctl.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && ctl.s_ready) begin
            op_reg   <= s_tuser;
            tpct_reg <= s_tdata[PCT_W-1:0];
            mdir_reg <= s_tdata[PCT_W +: DIR_W];
            amt_reg  <= s_tdata[PCT_W+DIR_W +: POS_W];
        end
        if (ctl.exec_other) begin
            ok_reg     <= 1'b0;
            pdir_reg   <= DIR_NONE;
            steps_reg  <= '0;
            target_reg <= '0;
            wd_reg     <= '0;
        end
        if (ctl.exec_plan) begin
            ok_reg <= 1'b1;
        end
        if (ctl.tgt_load) begin
            target_reg <= div_quot[POS_W-1:0];
        end
        if (ctl.plan_load) begin
            pdir_reg  <= pdir_next;
            steps_reg <= steps_next;
        end
        if (state_reg == ST_PCT) begin
            wd_reg <= WD_W'(steps_reg) + steps_round;
        end
        if (ctl.pct_fixed) begin
            opct_reg <= opct_fixed;
        end
        if (ctl.pct_load) begin
            opct_reg <= div_quot[OPCT_W-1:0];
        end
        if (ctl.out_load) begin
            m_tdata_reg <= {known_reg, opct_reg, pos_reg, wd_reg,
                            target_reg, steps_reg, pdir_reg, ok_reg};
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = ctl.s_ready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dspp_checker.sv
// Port-level assertions for the damper stepper position planner and their binding.
`default_nettype none

module dspp_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [dspp_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dspp_pkg::*;

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Requests are worked one at a time: no back-to-back acceptance.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    // An unknown position always reports a closed percent.
    a_unknown_pct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[71] |-> m_tdata[70:64] == '0)
        else $error("open percent reported for an unknown position");

    // Without a plan, every plan field is zero.
    a_no_plan_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[48:1] == '0)
        else $error("plan fields set without a plan");

    // A plan is only produced for a known position.
    a_plan_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[71])
        else $error("plan produced with the position unknown");

endmodule

bind damper_stepper_position_planner dspp_checker u_dspp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/sv/damper_stepper_position_planner_tb.sv
// Self-checking testbench for the damper stepper position planner.
`timescale 1ns / 1ps

module damper_stepper_position_planner_tb;
    import dspp_pkg::*;

    // Full-scale open percent, shared by the block and the predictor.
    localparam int PCT_FULL = 100;

    // The block leaves code 3 unnamed; it must be ignored.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // The direction code -2 must behave like any other closing code.
    localparam logic [DIR_W-1:0] DIR_CLOSE_ALT = 2'b10;

    // Leave a margin above the longest request, a successful plan.
    localparam int SETTLE_CYCLES = 100;

    // Far above the length of the slowest correct run.
    localparam int CYCLE_LIMIT = 800000;

    // Number of random phases and requests in each; each phase has its own range.
    localparam int PHASES = 14;
    localparam int PHASE_ITEMS = 125;

    // One result as it appears on m_tdata. The packed struct lists its fields
    // from the top bit down, so a plain cast of m_tdata lines up with it.
    typedef struct packed {
        logic              known;
        logic [OPCT_W-1:0] open_percent;
        logic [POS_W-1:0]  position;
        logic [WD_W-1:0]   watchdog;
        logic [POS_W-1:0]  target;
        logic [POS_W-1:0]  steps;
        logic [DIR_W-1:0]  direction;
        logic              ok;
    } planner_result_t;

    // Tracks the damper position the same way the block should, keeps the
    // results it predicts in arrival order and checks each result against
    // the oldest one.
    class planner_scoreboard;
        logic [POS_W-1:0] travel_range;
        logic [POS_W-1:0] position;
        bit               position_known;
        planner_result_t  pending[$];
        int unsigned      failures;
        int unsigned      checked;
        int unsigned      plans_made;
        int unsigned      plans_refused;

        function new();
            travel_range   = '0;
            position       = '0;
            position_known = 1'b0;
            failures       = 0;
            checked        = 0;
            plans_made     = 0;
            plans_refused  = 0;
        endfunction

        function void set_range(input logic [POS_W-1:0] travel_steps);
            travel_range = travel_steps;
        endfunction

        function bit idle();
            return pending.size() == 0;
        endfunction

        function void note_request(input logic [OP_W-1:0] op, input logic [PCT_W-1:0] pct,
                                   input logic [DIR_W-1:0] dcode,
                                   input logic [POS_W-1:0] amount);
            planner_result_t r;
            logic [31:0]     goal_pct;
            logic [31:0]     goal;
            logic [31:0]     guard;
            logic [POS_W+1:0] moved;
            r = '0;
            case (op)
                OP_PLAN: begin
                    if (position_known && travel_range != 0) begin
                        goal_pct = (pct > PCT_FULL) ? PCT_FULL : pct;
                        goal = (32'(travel_range) * goal_pct + PCT_FULL / 2) / PCT_FULL;
                        r.ok     = 1'b1;
                        r.target = goal[POS_W-1:0];
                        if (goal > position) begin
                            r.direction = DIR_OPEN;
                            r.steps     = goal[POS_W-1:0] - position;
                        end else if (goal < position) begin
                            r.direction = DIR_CLOSE;
                            r.steps     = position - goal[POS_W-1:0];
                        end
                        guard = (32'(r.steps) * 5 + 3) / 4;
                        r.watchdog = (guard > 32'hFFFF) ? 16'hFFFF : guard[WD_W-1:0];
                        plans_made++;
                    end else begin
                        plans_refused++;
                    end
                end
                OP_APPLY: begin
                    moved = {2'b00, position};
                    if (dcode == DIR_OPEN) begin
                        moved = moved + amount;
                    end else if (dcode[DIR_W-1]) begin
                        moved = (amount >= moved) ? '0 : moved - amount;
                    end
                    if (travel_range != 0 && moved > travel_range) begin
                        moved = {2'b00, travel_range};
                    end
                    if (moved > POS_MAX) begin
                        moved = {2'b00, POS_MAX};
                    end
                    position = moved[POS_W-1:0];
                end
                OP_SET: begin
                    position       = amount;
                    position_known = 1'b1;
                end
                default: begin
                end
            endcase
            r.position = position;
            r.known    = position_known;
            if (!position_known || travel_range == 0 || position == 0) begin
                r.open_percent = '0;
            end else if (position >= travel_range) begin
                r.open_percent = OPCT_W'(PCT_FULL);
            end else begin
                goal = (32'(position) * PCT_FULL + travel_range / 2) / travel_range;
                r.open_percent = goal[OPCT_W-1:0];
            end
            pending.push_back(r);
        endfunction

        function void check_field(input string name, input int unsigned want,
                                  input int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(input logic [M_TDATA_W-1:0] data);
            planner_result_t got;
            planner_result_t want;
            got = data;
            if (pending.size() == 0) begin
                $error("result arrived with no request outstanding: %h", data);
                failures++;
                return;
            end
            want = pending.pop_front();
            checked++;
            check_field("plan_ok", want.ok, got.ok);
            check_field("plan_direction", want.direction, got.direction);
            check_field("plan_steps", want.steps, got.steps);
            check_field("plan_target", want.target, got.target);
            check_field("watchdog_limit", want.watchdog, got.watchdog);
            check_field("current_position", want.position, got.position);
            check_field("current_open_pct", want.open_percent, got.open_percent);
            check_field("position_known", want.known, got.known);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [POS_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    // s_tdata, low bit up: target_pct, move_direction, step_amount, zero fill.
    logic [S_TDATA_W-1:0] s_tdata;
    // s_tuser: operation.
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // m_tdata, low bit up: plan_ok, plan_direction, plan_steps, plan_target,
    // watchdog_limit, current_position, current_open_pct, position_known.
    logic [M_TDATA_W-1:0] m_tdata;

    planner_scoreboard sb = new();

    // Number of requests accepted so far; it also paces the idle pattern and
    // the long receiver hold-off.
    int unsigned requests_sent = 0;
    int unsigned ranges_written = 0;

    // While this window of requests is in flight neither side ever idles.
    wire steady = (requests_sent >= 800) && (requests_sent < 1100);

    damper_stepper_position_planner #(
        .PERCENT_FULL(PCT_FULL)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // A hung block must not hang the run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("TIMEOUT after %0d cycles, %0d results still outstanding",
                 CYCLE_LIMIT, sb.pending.size());
        $display("FAILURE");
        $finish;
    end

    // Every accepted result is checked at the rising edge where it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // The receiver drops m_tready at random, about six times in a hundred. Once, after
    // a few hundred requests, it holds off for a long stretch while the sender
    // keeps offering, so the output register fills and s_tready must fall.
    initial begin
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && requests_sent >= 300) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (500) @(negedge aclk);
            end
            m_tready <= steady || ($urandom_range(99) >= 6);
        end
    end

    // Offers one request and returns at the falling edge after it is taken.
    // It is entered at a falling edge; valid stays high between back-to-back
    // requests unless a random idle cycle falls in between.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [PCT_W-1:0] pct,
                                input logic [DIR_W-1:0] dcode,
                                input logic [POS_W-1:0] amount);
        while (!steady && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - POS_W - DIR_W - PCT_W){1'b0}}, amount, dcode, pct};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, pct, dcode, amount);
        requests_sent++;
        @(negedge aclk);
    endtask

    // The travel range may only change while nothing is in flight, so drain
    // every result and let the block settle before the write.
    task automatic write_range(input logic [POS_W-1:0] travel_steps);
        s_tvalid <= 1'b0;
        while (!sb.idle()) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= travel_steps;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_range(travel_steps);
        ranges_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed requests with random content, scaled to the range so
    // that moves and set positions usually land inside the travel; the rest
    // are full-width values and the unused operation code.
    task automatic random_request();
        logic [OP_W-1:0]  op;
        logic [PCT_W-1:0] pct;
        logic [DIR_W-1:0] dcode;
        logic [POS_W-1:0] amount;
        int unsigned      pick;
        int unsigned      span;
        pick  = $urandom_range(99);
        span  = (sb.travel_range == 0) ? 64 : sb.travel_range;
        dcode = DIR_W'($urandom_range(3));
        if (pick < 3) begin
            op = OP_UNUSED;
        end else if (pick < 38) begin
            op = OP_PLAN;
        end else if (pick < 72) begin
            op = OP_APPLY;
        end else begin
            op = OP_SET;
        end
        if ($urandom_range(99) < 85) begin
            pct = PCT_W'($urandom_range(PCT_FULL));
        end else begin
            pct = PCT_W'($urandom_range(255));
        end
        if ($urandom_range(99) < 75) begin
            amount = POS_W'($urandom_range(span));
        end else begin
            amount = POS_W'($urandom);
        end
        send_request(op, pct, dcode, amount);
    endtask

    initial begin
        logic [POS_W-1:0] travel_steps;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Straight out of reset: no range and the position unknown. Plans must
        // be refused, while applies still move the position and saturate at the
        // field limits, with the flag staying unknown.
        send_request(OP_PLAN, 8'd50, DIR_NONE, '0);
        send_request(OP_APPLY, 8'hFF, DIR_OPEN, POS_MAX);
        send_request(OP_APPLY, 8'h00, DIR_OPEN, 15'd5);
        send_request(OP_APPLY, 8'h00, DIR_CLOSE_ALT, 15'd100);
        send_request(OP_APPLY, 8'h00, DIR_CLOSE, POS_MAX);
        // The unused code must leave everything alone.
        send_request(OP_UNUSED, 8'hFF, DIR_CLOSE, POS_MAX);
        // Homing makes the position known, but with no range a plan still fails.
        send_request(OP_SET, 8'h00, DIR_NONE, 15'd1234);
        send_request(OP_PLAN, 8'd100, DIR_NONE, '0);

        // A mid-size range: target clamping, moves clamped to the travel and a
        // set position beyond the travel.
        write_range(15'd1000);
        send_request(OP_PLAN, 8'hFF, DIR_NONE, '0);
        send_request(OP_SET, 8'h00, DIR_NONE, 15'd1000);
        send_request(OP_PLAN, 8'd0, DIR_NONE, '0);
        send_request(OP_APPLY, 8'h00, DIR_NONE, 15'd500);
        send_request(OP_APPLY, 8'h00, DIR_OPEN, POS_MAX);
        send_request(OP_SET, 8'h00, DIR_NONE, POS_MAX);
        send_request(OP_PLAN, 8'd50, DIR_NONE, '0);
        send_request(OP_APPLY, 8'h00, DIR_CLOSE, POS_MAX);

        // Widest range: the longest plan gives the largest watchdog.
        write_range(POS_MAX);
        send_request(OP_SET, 8'h00, DIR_NONE, POS_MAX);
        send_request(OP_PLAN, 8'd0, DIR_NONE, '0);
        send_request(OP_SET, 8'h00, DIR_NONE, '0);
        send_request(OP_PLAN, 8'd101, DIR_NONE, '0);
        send_request(OP_APPLY, 8'h00, DIR_OPEN, 15'd1);

        // Smallest nonzero range: rounding right at the half step.
        write_range(15'd1);
        send_request(OP_SET, 8'h00, DIR_NONE, '0);
        send_request(OP_PLAN, 8'd50, DIR_NONE, '0);
        send_request(OP_PLAN, 8'd49, DIR_NONE, '0);

        // Random phases, each under its own travel range; the extremes recur.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 5)
                0: travel_steps = '0;
                1: travel_steps = 15'd1;
                2: travel_steps = POS_MAX;
                3: travel_steps = POS_W'($urandom_range(200, 2));
                default: travel_steps = POS_W'($urandom_range(32767, 201));
            endcase
            write_range(travel_steps);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_request();
            end
        end

        s_tvalid <= 1'b0;
        while (!sb.idle()) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (!sb.idle()) begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.failures++;
        end

        $display("Checked %0d results from %0d requests over %0d travel range settings.",
                 sb.checked, requests_sent, ranges_written);
        $display("Plans produced: %0d, plans refused: %0d, mismatches: %0d.",
                 sb.plans_made, sb.plans_refused, sb.failures);
        if (sb.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
